// ----- rtl/core/bpe_pkg.sv -----
// Bezier patch evaluator package: request and result types, command and
// status structs shared by the controller and the datapath. No dependencies.
package bpe_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         point_row;
    logic [1:0]         point_col;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        param_u;
    logic [16:0]        param_v;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;
  } out_item_t;

  // where the interpolator takes its next point from
  typedef enum logic [1:0] {
    SRC_STORE = 2'd0,
    SRC_WORK  = 2'd1,
    SRC_ROW   = 2'd2
  } src_t;

  // where an interpolation result goes
  typedef enum logic [1:0] {
    DEST_WORK = 2'd0,
    DEST_ROW  = 2'd1,
    DEST_OUT  = 2'd2
  } dest_t;

  typedef struct packed {
    logic  vld;
    src_t  src;
    logic  compute;
    dest_t dest;
    logic  use_v;
  } cmd_t;

  typedef struct packed {
    logic load;
    logic start;
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/bpe_queue.sv -----
// Shift-down point queue, head read at a fixed place.
// Depends on bpe_pkg (point_t).
module bpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpe_pkg::point_t push_data,
  input  logic            pop,
  output bpe_pkg::point_t head
);

  localparam int CW = $clog2(DEPTH + 1);

  bpe_pkg::point_t q_r   [DEPTH];
  bpe_pkg::point_t q_nxt [DEPTH];
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   widx;

  assign head = q_r[0];
  assign widx = pop ? (cnt_r - CW'(1)) : cnt_r;

  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
      if (push && (widx == CW'(i))) q_nxt[i] = push_data;
    end
    q_nxt[DEPTH-1] = q_r[DEPTH-1];
    if (push && (widx == CW'(DEPTH - 1))) q_nxt[DEPTH-1] = push_data;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) q_r[i] <= q_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/bpe_ctrl.sv -----
// Evaluator controller: request acceptance and the de Casteljau schedule.
// Depends on bpe_pkg (ctl_t, sts_t, command codes).
module bpe_ctrl #(
  parameter int GRID_SIZE = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_opcode,
  output logic                                 in_stall,
  input  bpe_pkg::sts_t                        sts,
  output bpe_pkg::ctl_t                        ctl,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr
);

  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int LW = $clog2(GRID_SIZE + 1);
  localparam int RW = $clog2(GRID_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic          col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          accept;
  logic          first_lvl, last_lvl;

  assign in_stall  = (state_r != ST_IDLE) || ((in_opcode == bpe_pkg::OP_EVAL) && sts.out_busy);
  assign accept    = in_valid && !in_stall;
  assign first_lvl = (len_r == LW'(GRID_SIZE));
  assign last_lvl  = (len_r == LW'(2));
  assign rd_addr   = addr_r;

  always_comb begin
    ctl.load        = accept && (in_opcode == bpe_pkg::OP_LOAD);
    ctl.start       = accept && (in_opcode == bpe_pkg::OP_EVAL);
    ctl.cmd.vld     = (state_r == ST_RUN);
    ctl.cmd.src     = first_lvl ? (col_r ? bpe_pkg::SRC_ROW : bpe_pkg::SRC_STORE)
                                : bpe_pkg::SRC_WORK;
    ctl.cmd.compute = (pos_r != '0);
    ctl.cmd.dest    = last_lvl ? (col_r ? bpe_pkg::DEST_OUT : bpe_pkg::DEST_ROW)
                               : bpe_pkg::DEST_WORK;
    ctl.cmd.use_v   = col_r;
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    addr_nxt  = addr_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          state_nxt = ST_RUN;
          col_nxt   = 1'b0;
          row_nxt   = '0;
          len_nxt   = LW'(GRID_SIZE);
          pos_nxt   = '0;
          addr_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (ctl.cmd.src == bpe_pkg::SRC_STORE) addr_nxt = addr_r + AW'(1);
        if (pos_r == len_r - LW'(1)) begin
          pos_nxt = '0;
          if (last_lvl) begin
            len_nxt = LW'(GRID_SIZE);
            if (col_r) begin
              state_nxt = ST_DRAIN;
            end else if (row_r == RW'(GRID_SIZE - 1)) begin
              col_nxt = 1'b1;
              row_nxt = '0;
            end else begin
              row_nxt = row_r + RW'(1);
            end
          end else begin
            len_nxt = len_r - LW'(1);
          end
        end else begin
          pos_nxt = pos_r + LW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= 1'b0;
      row_r   <= '0;
      len_r   <= LW'(GRID_SIZE);
      pos_r   <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// ----- rtl/core/bpe_dpath.sv -----
// Evaluator datapath: control point store, shared three-coordinate
// interpolator, work and row queues, output register. Depends on bpe_pkg, bpe_queue.
module bpe_dpath #(
  parameter int GRID_SIZE = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bpe_pkg::in_item_t                    in_data,
  input  bpe_pkg::ctl_t                        ctl,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
  output bpe_pkg::sts_t                        sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bpe_pkg::out_item_t                   out_data
);

  localparam int D  = GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(D);

  function automatic logic [16:0] clamp_t(input logic [16:0] p);
    clamp_t = (p > bpe_pkg::ONE_Q16) ? bpe_pkg::ONE_Q16 : p;
  endfunction

  bpe_pkg::point_t    mem [D];
  logic [D-1:0]       vld_r;
  bpe_pkg::point_t    rd_pt_r;
  logic               rd_ok_r;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  bpe_pkg::point_t    wr_pt;

  logic [16:0]        u_r, v_r;
  bpe_pkg::cmd_t      cmd_r;
  bpe_pkg::point_t    cur, prev_r, res;
  bpe_pkg::point_t    wq_head, rq_head;
  logic [16:0]        t_sel, t_inv;
  logic signed [31:0] cur_c [3];
  logic signed [31:0] prv_c [3];
  logic signed [49:0] pa_r  [3];
  logic signed [49:0] pb_r  [3];
  logic signed [50:0] sum   [3];
  logic               m_vld_r;
  bpe_pkg::dest_t     m_dest_r;
  logic               out_valid_r;
  bpe_pkg::out_item_t out_data_r;

  // load path: requests outside the grid are dropped
  assign wr_en   = ctl.load && (int'(in_data.point_row) < GRID_SIZE)
                            && (int'(in_data.point_col) < GRID_SIZE);
  assign wr_addr = AW'(int'(in_data.point_row) * GRID_SIZE + int'(in_data.point_col));
  assign wr_pt   = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_pt;
    rd_pt_r <= mem[rd_addr];
    rd_ok_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      u_r <= clamp_t(in_data.param_u);
      v_r <= clamp_t(in_data.param_v);
    end
  end

  // execute stage: the issued command, registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= ctl.cmd;
    end
  end

  always_comb begin
    case (cmd_r.src)
      bpe_pkg::SRC_STORE: cur = rd_ok_r ? rd_pt_r : '0;
      bpe_pkg::SRC_WORK:  cur = wq_head;
      bpe_pkg::SRC_ROW:   cur = rq_head;
      default:            cur = '0;
    endcase
  end

  assign t_sel = cmd_r.use_v ? v_r : u_r;
  assign t_inv = bpe_pkg::ONE_Q16 - t_sel;

  always_comb begin
    cur_c[0] = cur.x;    cur_c[1] = cur.y;    cur_c[2] = cur.z;
    prv_c[0] = prev_r.x; prv_c[1] = prev_r.y; prv_c[2] = prev_r.z;
  end

  always_ff @(posedge clk) begin
    if (cmd_r.vld) prev_r <= cur;
    for (int c = 0; c < 3; c++) begin
      pa_r[c] <= prv_c[c] * $signed({1'b0, t_inv});
      pb_r[c] <= cur_c[c] * $signed({1'b0, t_sel});
    end
    m_dest_r <= cmd_r.dest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= cmd_r.vld && cmd_r.compute;
    end
  end

  // floor of the exact sum by 2^16
  always_comb begin
    for (int c = 0; c < 3; c++) sum[c] = 51'(pa_r[c]) + 51'(pb_r[c]);
    res.x = sum[0][47:16];
    res.y = sum[1][47:16];
    res.z = sum[2][47:16];
  end

  bpe_queue #(.DEPTH(GRID_SIZE)) u_work_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m_vld_r && (m_dest_r == bpe_pkg::DEST_WORK)),
    .push_data (res),
    .pop       (cmd_r.vld && (cmd_r.src == bpe_pkg::SRC_WORK)),
    .head      (wq_head)
  );

  bpe_queue #(.DEPTH(GRID_SIZE)) u_row_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m_vld_r && (m_dest_r == bpe_pkg::DEST_ROW)),
    .push_data (res),
    .pop       (cmd_r.vld && (cmd_r.src == bpe_pkg::SRC_ROW)),
    .head      (rq_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_vld_r && (m_dest_r == bpe_pkg::DEST_OUT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_vld_r && (m_dest_r == bpe_pkg::DEST_OUT)) begin
      out_data_r <= '{surf_x: res.x, surf_y: res.y, surf_z: res.z};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.pipe_busy = cmd_r.vld || m_vld_r;
  assign sts.out_busy  = out_valid_r && out_stall;

endmodule

// ----- rtl/core/bezier_patch_evaluator.sv -----
// Bezier patch evaluator top level: controller plus datapath.
// Load request: stores a control point, no result. Evaluate request: one result,
// computed by the single interpolator taking one point a cycle plus its two-stage
// drain; requests are held off until the drain is done. Reset: synchronous, clears
// control, store valid bits (all points read zero) and the output valid flag.
module bezier_patch_evaluator #(
  parameter int GRID_SIZE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpe_pkg::out_item_t out_data
);

  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

  bpe_pkg::ctl_t ctl;
  bpe_pkg::sts_t sts;
  logic [AW-1:0] rd_addr;

  bpe_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .ctl       (ctl),
    .rd_addr   (rd_addr)
  );

  bpe_dpath #(.GRID_SIZE(GRID_SIZE)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/bpe_checker.sv -----
// Port-level checks for the Bezier patch evaluator, bound to the top level.
// Depends on bpe_pkg.
module bpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bpe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bpe_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == bpe_pkg::OP_EVAL) |=> in_stall)
    else $error("evaluate request did not hold off the next request");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bezier_patch_evaluator bpe_checker u_bpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/bpe_surface_checker.sv -----
// Surface checker for the Bezier patch evaluator: tracks the control grid from
// accepted load requests, predicts each evaluated point and compares results.
// Depends on bpe_pkg only.
module bpe_surface_checker #(
  parameter int GRID_SIZE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bpe_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bpe_pkg::out_item_t out_data,
  output int                 error_count,
  output int                 pending
);

  typedef bpe_pkg::point_t [GRID_SIZE-1:0] line_t;

  bpe_pkg::point_t    ctrl_grid [GRID_SIZE*GRID_SIZE];
  bpe_pkg::out_item_t surface_q [$];
  int                 errors = 0;
  int                 waiting = 0;

  assign error_count = errors;
  assign pending     = waiting;

  function automatic logic [16:0] clamp_t(input logic [16:0] t);
    return (t > bpe_pkg::ONE_Q16) ? bpe_pkg::ONE_Q16 : t;
  endfunction

  // a*(1-t) + b*t, floored to Q16.16
  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [16:0] t);
    longint s;
    s = longint'(a) * (longint'(bpe_pkg::ONE_Q16) - longint'(t)) + longint'(b) * longint'(t);
    return 32'(s >>> 16);
  endfunction

  function automatic line_t collapse_step(input line_t pts, input int n,
                                          input logic [16:0] t);
    line_t w;
    w = pts;
    for (int i = 0; i + 1 < n; i++) begin
      w[i].x = blend(w[i].x, w[i+1].x, t);
      w[i].y = blend(w[i].y, w[i+1].y, t);
      w[i].z = blend(w[i].z, w[i+1].z, t);
    end
    return w;
  endfunction

  function automatic bpe_pkg::point_t collapse_line(input line_t pts, input logic [16:0] t);
    line_t w;
    w = pts;
    for (int n = GRID_SIZE; n > 1; n--)
      w = collapse_step(w, n, t);
    return w[0];
  endfunction

  function automatic bpe_pkg::out_item_t surface_at(input logic [16:0] u_raw,
                                                    input logic [16:0] v_raw);
    line_t           row_pts;
    line_t           col_pts;
    bpe_pkg::point_t p;
    logic [16:0]     u;
    logic [16:0]     v;
    u = clamp_t(u_raw);
    v = clamp_t(v_raw);
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int k = 0; k < GRID_SIZE; k++)
        row_pts[k] = ctrl_grid[r*GRID_SIZE + k];
      col_pts[r] = collapse_line(row_pts, u);
    end
    p = collapse_line(col_pts, v);
    return '{surf_x: p.x, surf_y: p.y, surf_z: p.z};
  endfunction

  task automatic check_coord(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bpe_pkg::out_item_t want;
    int                 slot;
    if (!rst_n) begin
      foreach (ctrl_grid[i]) ctrl_grid[i] = '0;
      surface_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (surface_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, expected none, got %h",
                   $time, out_data);
        end else begin
          want = surface_q.pop_front();
          check_coord("surf_x", want.surf_x, out_data.surf_x);
          check_coord("surf_y", want.surf_y, out_data.surf_y);
          check_coord("surf_z", want.surf_z, out_data.surf_z);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == bpe_pkg::OP_LOAD) begin
          if (in_data.point_row < GRID_SIZE && in_data.point_col < GRID_SIZE) begin
            slot = in_data.point_row * GRID_SIZE + in_data.point_col;
            ctrl_grid[slot] = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
          end
        end else begin
          surface_q.insert(surface_q.size(), surface_at(in_data.param_u, in_data.param_v));
        end
      end
    end
    waiting = surface_q.size();
  end

endmodule

// ----- tb/bezier_patch_evaluator_test.sv -----
// Testbench top for the Bezier patch evaluator: clock, reset, request and
// result stall stimulus and the verdict. Depends on bpe_pkg, the block and
// bpe_surface_checker.
module bezier_patch_evaluator_test;

  localparam int GRID           = 4;
  localparam int EVAL_LATENCY   = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1250;
  localparam int QUIET_FROM     = 1100;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bpe_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bpe_pkg::out_item_t out_data;
  int                 error_count;
  int                 pending;
  bit                 quiet     = 1'b0;
  bit                 hold_req  = 1'b0;
  int                 gap_chance = 25;
  int                 sent_count = 0;

  bezier_patch_evaluator #(.GRID_SIZE(GRID)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  bpe_surface_checker #(.GRID_SIZE(GRID)) surf_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .error_count(error_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("bezier_patch_evaluator_test: done, errors");
    $finish;
  end

  // result side stall bursts; a long hold on demand
  initial begin
    int burst;
    bit stall_val;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        burst     = HOLD_CYCLES;
        stall_val = 1'b1;
        hold_req  = 1'b0;
      end else if (quiet) begin
        burst     = 1;
        stall_val = 1'b0;
      end else begin
        burst     = $urandom_range(1, 18);
        stall_val = ($urandom_range(0, 2) == 0);
      end
      out_stall <= stall_val;
      repeat (burst) @(negedge clk);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return bpe_pkg::ONE_Q16;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'($urandom_range(0, 255));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic bpe_pkg::in_item_t load_item(input logic [1:0] row,
                                                  input logic [1:0] col,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
    bpe_pkg::in_item_t item;
    item.opcode    = bpe_pkg::OP_LOAD;
    item.point_row = row;
    item.point_col = col;
    item.coord_x   = x;
    item.coord_y   = y;
    item.coord_z   = z;
    item.param_u   = 17'($urandom);
    item.param_v   = 17'($urandom);
    return item;
  endfunction

  function automatic bpe_pkg::in_item_t eval_item(input logic [16:0] u,
                                                  input logic [16:0] v);
    bpe_pkg::in_item_t item;
    item.opcode    = bpe_pkg::OP_EVAL;
    item.point_row = 2'($urandom);
    item.point_col = 2'($urandom);
    item.coord_x   = $urandom();
    item.coord_y   = $urandom();
    item.coord_z   = $urandom();
    item.param_u   = u;
    item.param_v   = v;
    return item;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_request(input bpe_pkg::in_item_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send(input bpe_pkg::in_item_t item);
    push_request(item);
    if (!quiet && gap_chance != 0 && $urandom_range(1, 100) <= gap_chance) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // hold the result side off and keep offering evaluations so the block backs up
  task automatic hold_and_flood();
    in_valid <= 1'b0;
    hold_req = 1'b1;
    do @(negedge clk); while (hold_req);
    repeat (6) push_request(eval_item(rand_param(), rand_param()));
  endtask

  initial begin
    int order [GRID*GRID];
    int j;
    int tmp;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // cleared grid and a saturated evaluation, then an extreme grid and its corner cases
    send(eval_item('0, '0));
    send(eval_item(17'h1FFFF, 17'h1FFFF));
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++)
        send(load_item(2'(r), 2'(c), ((r + c) % 2 != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                       (r == c) ? 32'h0 : 32'hFFFF_FFFF, $urandom()));
    send(eval_item('0, '0));
    send(eval_item(bpe_pkg::ONE_Q16, bpe_pkg::ONE_Q16));
    send(eval_item(bpe_pkg::ONE_Q16, '0));
    send(eval_item('0, bpe_pkg::ONE_Q16));
    send(eval_item(17'h08000, 17'h08000));
    send(eval_item(17'h1FFFF, 17'h10001));
    drain();
    hold_and_flood();

    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= QUIET_FROM) quiet = 1'b1;
      gap_chance = ($urandom_range(0, 2) == 0) ? 0 : 25;
      case ($urandom_range(0, quiet ? 7 : 9))
        0, 1, 2, 3, 4, 5: begin
          // whole patch in random order, then a few evaluations of it
          foreach (order[i]) order[i] = i;
          for (int i = GRID*GRID - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          foreach (order[i])
            send(load_item(2'(order[i] / GRID), 2'(order[i] % GRID),
                           rand_coord(), rand_coord(), rand_coord()));
          repeat ($urandom_range(1, 4)) send(eval_item(rand_param(), rand_param()));
        end
        6, 7: begin
          repeat (8)
            send($urandom_range(0, 1) ?
                 load_item(2'($urandom), 2'($urandom), rand_coord(), rand_coord(),
                           rand_coord()) :
                 eval_item(rand_param(), rand_param()));
        end
        8:       hold_and_flood();
        default: drain();
      endcase
    end

    drain();
    repeat (EVAL_LATENCY) @(negedge clk);
    if (error_count == 0 && pending == 0)
      $display("bezier_patch_evaluator_test: done, clean");
    else
      $display("bezier_patch_evaluator_test: done, errors");
    $finish;
  end

endmodule
